// ===== rtl/snb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package snb_pkg;

	// Sample and coefficient formats.
	localparam int SAMPLE_WIDTH   = 16;
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_WIDTH     = COEF_FRAC_BITS + 3;
	localparam int STAMP_WIDTH    = 32;

	// Channel layout: three accelerometer lanes followed by three gyro lanes.
	localparam int NUM_LANES      = 6;
	localparam int NUM_ACC_LANES  = 3;

	// Configuration port.
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = COEF_WIDTH;

	// Datapath widths: one coefficient times one sample, and the exact sum of
	// all terms with room for growth.
	localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
	localparam int ACC_WIDTH  = PROD_WIDTH + 3;

	// Half an output LSB, added before the flooring shift.
	localparam logic signed [ACC_WIDTH-1:0] RND_HALF =
		{{(ACC_WIDTH-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

	// Saturation bounds of the sample range, at accumulator width.
	localparam logic signed [ACC_WIDTH-1:0] SAT_MAX =
		{{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] SAT_MIN =
		{{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic        [STAMP_WIDTH-1:0]  stamp_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;

	// Register map.
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ACC_B1      = 3'd0,
		REG_ACC_A1      = 3'd1,
		REG_ACC_A2      = 3'd2,
		REG_ACC_BYPASS  = 3'd3,
		REG_GYRO_B1     = 3'd4,
		REG_GYRO_A1     = 3'd5,
		REG_GYRO_A2     = 3'd6,
		REG_GYRO_BYPASS = 3'd7
	} snb_reg_t;

	// Coefficient set shared by one channel group.
	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] b1;
		logic signed [COEF_WIDTH-1:0] a1;
		logic signed [COEF_WIDTH-1:0] a2;
		logic                         bypass;
	} snb_coef_t;

endpackage

`default_nettype wire

// ===== rtl/snb_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface snb_in_if;
	logic              valid;
	logic              ready;
	snb_pkg::sample_t  accel_x;
	snb_pkg::sample_t  accel_y;
	snb_pkg::sample_t  accel_z;
	snb_pkg::sample_t  gyro_x;
	snb_pkg::sample_t  gyro_y;
	snb_pkg::sample_t  gyro_z;
	snb_pkg::stamp_t   sample_time;
	snb_pkg::stamp_t   sample_interval;

	modport source (
		output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		       sample_time, sample_interval,
		input  ready
	);

	modport sink (
		input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		       sample_time, sample_interval,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/snb_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface snb_out_if;
	logic              valid;
	logic              ready;
	snb_pkg::sample_t  accel_x_out;
	snb_pkg::sample_t  accel_y_out;
	snb_pkg::sample_t  accel_z_out;
	snb_pkg::sample_t  gyro_x_out;
	snb_pkg::sample_t  gyro_y_out;
	snb_pkg::sample_t  gyro_z_out;
	snb_pkg::stamp_t   time_out;
	snb_pkg::stamp_t   interval_out;

	modport source (
		output valid, accel_x_out, accel_y_out, accel_z_out,
		       gyro_x_out, gyro_y_out, gyro_z_out, time_out, interval_out,
		input  ready
	);

	modport sink (
		input  valid, accel_x_out, accel_y_out, accel_z_out,
		       gyro_x_out, gyro_y_out, gyro_z_out, time_out, interval_out,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/snb_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One notch channel. The feed-forward terms and the a2 term for the next
// sample are summed ahead of time into part_q, so only a1*y1 sits in the
// recursive path.
module snb_lane (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic               primed,
	input  wire snb_pkg::snb_coef_t coef,
	input  wire snb_pkg::sample_t   x,
	output      snb_pkg::sample_t   y
);

	snb_pkg::sample_t                            x1_q;
	snb_pkg::sample_t                            y1_q;
	logic signed [snb_pkg::ACC_WIDTH-1:0]        part_q;

	snb_pkg::sample_t                            x_prev;
	snb_pkg::sample_t                            y_prev;
	logic signed [snb_pkg::PROD_WIDTH-1:0]       prod_a1;
	logic signed [snb_pkg::PROD_WIDTH-1:0]       prod_b1;
	logic signed [snb_pkg::PROD_WIDTH-1:0]       prod_a2;
	logic signed [snb_pkg::ACC_WIDTH-1:0]        part_d;
	logic signed [snb_pkg::ACC_WIDTH-1:0]        sum;
	logic signed [snb_pkg::ACC_WIDTH-1:0]        rnd;
	snb_pkg::sample_t                            sat;

	// While priming, the whole history takes the current sample.
	assign x_prev = primed ? x1_q : x;
	assign y_prev = primed ? y1_q : x;

	assign prod_a1 = coef.a1 * y1_q;
	assign prod_b1 = coef.b1 * x;
	assign prod_a2 = coef.a2 * y_prev;

	assign part_d = snb_pkg::ACC_WIDTH'(prod_b1)
		+ (snb_pkg::ACC_WIDTH'(x_prev) <<< snb_pkg::COEF_FRAC_BITS)
		- snb_pkg::ACC_WIDTH'(prod_a2);

	assign sum = (snb_pkg::ACC_WIDTH'(x) <<< snb_pkg::COEF_FRAC_BITS)
		+ part_q - snb_pkg::ACC_WIDTH'(prod_a1) + snb_pkg::RND_HALF;

	assign rnd = sum >>> snb_pkg::COEF_FRAC_BITS;

	always_comb begin
		if (rnd > snb_pkg::SAT_MAX) begin
			sat = snb_pkg::SAT_MAX[snb_pkg::SAMPLE_WIDTH-1:0];
		end else if (rnd < snb_pkg::SAT_MIN) begin
			sat = snb_pkg::SAT_MIN[snb_pkg::SAMPLE_WIDTH-1:0];
		end else begin
			sat = rnd[snb_pkg::SAMPLE_WIDTH-1:0];
		end
	end

	assign y = (!primed || coef.bypass) ? x : sat;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_q   <= x;
			y1_q   <= y;
			part_q <= part_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/six_channel_notch_biquad_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Six-channel IMU notch filter.
// An item on the sample channel carries three accelerometer and three gyro
// samples plus a timestamp and an interval word. Each of the six lanes runs a
// direct form I notch (b0 = b2 = 1) and the result item on the result channel
// carries the six rounded, saturated outputs and the two words unchanged.
// Coefficients and bypass flags are written through cfg_we / cfg_index /
// cfg_data; the user must write them only while the block is idle, which is
// not enforced. Any write makes the next item prime the filters: it passes
// through and fills every history register with itself. An item's result is
// valid on the cycle after it is accepted. Throughput is one item per cycle
// while results are taken; the per-lane path of one a1*y1 multiply, the final
// add, rounding and saturation sets that figure. The result register keeps
// taking new items while the receiver takes the previous one; when the
// receiver stalls, the result holds and sample.ready drops until it is taken.
// Reset clears the result valid, loads zero coefficients with both groups in
// bypass, and leaves the filters unprimed.
module six_channel_notch_biquad_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [snb_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  wire logic [snb_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
	snb_in_if.sink                                     sample,
	snb_out_if.source                                  result
);

	snb_pkg::snb_coef_t acc_coef_q;
	snb_pkg::snb_coef_t gyro_coef_q;
	logic               primed_q;
	logic               out_valid_q;
	logic               in_acc;

	snb_pkg::sample_t   x_lane [snb_pkg::NUM_LANES];
	snb_pkg::sample_t   y_lane [snb_pkg::NUM_LANES];
	snb_pkg::sample_t   y_q    [snb_pkg::NUM_LANES];
	snb_pkg::stamp_t    time_q;
	snb_pkg::stamp_t    interval_q;

	// The result register frees up whenever it is empty or being taken.
	assign sample.ready = !out_valid_q || result.ready;
	assign in_acc       = sample.valid && sample.ready;

	// Configuration registers. Every write re-arms priming.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_coef_q  <= '{b1: '0, a1: '0, a2: '0, bypass: 1'b1};
			gyro_coef_q <= '{b1: '0, a1: '0, a2: '0, bypass: 1'b1};
			primed_q    <= 1'b0;
		end else if (cfg_we) begin
			primed_q <= 1'b0;
			case (snb_pkg::snb_reg_t'(cfg_index))
				snb_pkg::REG_ACC_B1:      acc_coef_q.b1      <= cfg_data;
				snb_pkg::REG_ACC_A1:      acc_coef_q.a1      <= cfg_data;
				snb_pkg::REG_ACC_A2:      acc_coef_q.a2      <= cfg_data;
				snb_pkg::REG_ACC_BYPASS:  acc_coef_q.bypass  <= cfg_data[0];
				snb_pkg::REG_GYRO_B1:     gyro_coef_q.b1     <= cfg_data;
				snb_pkg::REG_GYRO_A1:     gyro_coef_q.a1     <= cfg_data;
				snb_pkg::REG_GYRO_A2:     gyro_coef_q.a2     <= cfg_data;
				snb_pkg::REG_GYRO_BYPASS: gyro_coef_q.bypass <= cfg_data[0];
				default: begin
				end
			endcase
		end else if (in_acc) begin
			primed_q <= 1'b1;
		end
	end

	assign x_lane[0] = sample.accel_x;
	assign x_lane[1] = sample.accel_y;
	assign x_lane[2] = sample.accel_z;
	assign x_lane[3] = sample.gyro_x;
	assign x_lane[4] = sample.gyro_y;
	assign x_lane[5] = sample.gyro_z;

	// Six lanes; the first group uses the accelerometer set, the rest gyro.
	for (genvar i = 0; i < snb_pkg::NUM_LANES; i++) begin : g_lane
		snb_pkg::snb_coef_t lane_coef;

		if (i < snb_pkg::NUM_ACC_LANES) begin : g_acc
			assign lane_coef = acc_coef_q;
		end else begin : g_gyro
			assign lane_coef = gyro_coef_q;
		end

		snb_lane u_lane (
			.clk    (clk),
			.en     (in_acc),
			.primed (primed_q),
			.coef   (lane_coef),
			.x      (x_lane[i]),
			.y      (y_lane[i])
		);
	end

	// Merge stage: the lane outputs and the pass-through words are captured
	// together into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			y_q        <= y_lane;
			time_q     <= sample.sample_time;
			interval_q <= sample.sample_interval;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.accel_x_out  = y_q[0];
	assign result.accel_y_out  = y_q[1];
	assign result.accel_z_out  = y_q[2];
	assign result.gyro_x_out   = y_q[3];
	assign result.gyro_y_out   = y_q[4];
	assign result.gyro_z_out   = y_q[5];
	assign result.time_out     = time_q;
	assign result.interval_out = interval_q;

`ifndef ASSERT_OFF
	// A configuration write always leaves the filters unprimed.
	a_cfg_unprimes: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !primed_q)
		else $error("priming not re-armed after a configuration write");

	// An accepted item always produces a pending result on the next cycle.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted item produced no result");

	// A priming item passes its samples through unchanged (checked on accel_x and gyro_z).
	a_prime_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !primed_q) |=>
			(result.accel_x_out == $past(sample.accel_x)) &&
			(result.gyro_z_out == $past(sample.gyro_z)))
		else $error("priming item was not passed through");
`endif

endmodule

`default_nettype wire
